@@ hw/rtl/pbpb_pkg.sv @@
package pbpb_pkg;

  localparam int COEFF_MAX = 5;
  localparam int COEFF_W   = 48;
  localparam int PEAK_W    = 32;
  localparam int CFG_W     = 48;
  localparam int COORD_W   = 24;
  localparam int R2_W      = 48;
  localparam int ACC_W     = 51;
  localparam int MAG_W     = 50;
  localparam int HALF_W    = 25;
  localparam int OUT_FRAC_W = 24;

  typedef enum logic [2:0] {
    REG_COEFF0 = 3'd0,
    REG_COEFF1 = 3'd1,
    REG_COEFF2 = 3'd2,
    REG_COEFF3 = 3'd3,
    REG_COEFF4 = 3'd4,
    REG_PEAK   = 3'd5
  } cfg_reg_t;

  typedef logic signed [COEFF_W-1:0] coef_t;
  typedef coef_t [COEFF_MAX-1:0] coef_arr_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_FRAC_W-1:0] fraction;
    logic [PEAK_W-1:0]     pressure;
    logic                  outside;
  } out_beat_t;

  // control that rides along with every beat through the chain
  typedef struct packed {
    logic            valid;
    logic            outside;
    logic            center;
    logic [R2_W-1:0] r2;
  } side_t;

endpackage

@@ hw/rtl/pbpb_horner_cell.sv @@
module pbpb_horner_cell
  import pbpb_pkg::*;
#(
  parameter int FRACTION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  side_t                    side_i,
  input  logic [FRACTION_BITS-1:0] mid_i,
  input  logic signed [ACC_W-1:0]  acc_i,
  input  coef_t                    coeff_i,
  output side_t                    side_o,
  output logic [FRACTION_BITS-1:0] mid_o,
  output logic signed [ACC_W-1:0]  acc_o
);

  localparam int PROD_W = HALF_W + FRACTION_BITS;
  localparam int FULL_W = MAG_W + FRACTION_BITS;

  logic [ACC_W-1:0]         mag_full;
  logic [MAG_W-1:0]         mag;
  side_t                    side_a_r;
  logic [FRACTION_BITS-1:0] mid_a_r;
  logic                     neg_a_r;
  logic [PROD_W-1:0]        pl_a_r, ph_a_r;
  logic [FULL_W-1:0]        full;
  logic [MAG_W-1:0]         q;
  logic signed [ACC_W-1:0]  term, acc_nxt;
  side_t                    side_b_r;
  logic [FRACTION_BITS-1:0] mid_b_r;
  logic signed [ACC_W-1:0]  acc_b_r;

  assign mag_full = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : acc_i;
  assign mag      = mag_full[MAG_W-1:0];

  // stage A: two partial products of |acc| * mid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r.valid <= 1'b0;
    end else if (adv) begin
      side_a_r.valid <= side_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_a_r.outside <= side_i.outside;
      side_a_r.center  <= side_i.center;
      side_a_r.r2      <= side_i.r2;
      mid_a_r <= mid_i;
      neg_a_r <= acc_i[ACC_W-1];
      pl_a_r  <= PROD_W'(mag[HALF_W-1:0]) * PROD_W'(mid_i);
      ph_a_r  <= PROD_W'(mag[MAG_W-1:HALF_W]) * PROD_W'(mid_i);
    end
  end

  // stage B: recombine, truncate toward zero, add coefficient
  assign full    = (FULL_W'(ph_a_r) << HALF_W) + FULL_W'(pl_a_r);
  assign q       = full[FRACTION_BITS +: MAG_W];
  assign term    = neg_a_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign acc_nxt = term + $signed({{(ACC_W-COEFF_W){coeff_i[COEFF_W-1]}}, coeff_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_b_r.valid <= 1'b0;
    end else if (adv) begin
      side_b_r.valid <= side_a_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_b_r.outside <= side_a_r.outside;
      side_b_r.center  <= side_a_r.center;
      side_b_r.r2      <= side_a_r.r2;
      mid_b_r <= mid_a_r;
      acc_b_r <= acc_nxt;
    end
  end

  assign side_o = side_b_r;
  assign mid_o  = mid_b_r;
  assign acc_o  = acc_b_r;

endmodule

@@ hw/rtl/pbpb_bisect_cell.sv @@
module pbpb_bisect_cell
  import pbpb_pkg::*;
#(
  parameter int FRACTION_BITS = 24,
  parameter int COEFF_COUNT   = 5,
  parameter int BIT_POS       = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  coef_arr_t                coeff_i,
  input  side_t                    side_i,
  input  logic [FRACTION_BITS-1:0] lo_i,
  output side_t                    side_o,
  output logic [FRACTION_BITS-1:0] lo_o
);

  localparam int STEPS = COEFF_COUNT - 1;
  localparam logic [FRACTION_BITS-1:0] BIT = FRACTION_BITS'(1) << BIT_POS;

  side_t                    side_w [STEPS+1];
  logic [FRACTION_BITS-1:0] mid_w  [STEPS+1];
  logic signed [ACC_W-1:0]  acc_w  [STEPS+1];
  coef_t                    top_c;
  side_t                    side_r;
  logic [FRACTION_BITS-1:0] lo_r;
  logic                     hit;

  assign top_c     = coeff_i[COEFF_COUNT-1];
  assign side_w[0] = side_i;
  assign mid_w[0]  = lo_i | BIT;
  assign acc_w[0]  = $signed({{(ACC_W-COEFF_W){top_c[COEFF_W-1]}}, top_c});

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    pbpb_horner_cell #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_horner (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .side_i (side_w[s]),
      .mid_i  (mid_w[s]),
      .acc_i  (acc_w[s]),
      .coeff_i(coeff_i[COEFF_COUNT-2-s]),
      .side_o (side_w[s+1]),
      .mid_o  (mid_w[s+1]),
      .acc_o  (acc_w[s+1])
    );
  end

  assign hit = acc_w[STEPS] > $signed({{(ACC_W-R2_W){1'b0}}, side_w[STEPS].r2});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (adv) begin
      side_r.valid <= side_w[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r.outside <= side_w[STEPS].outside;
      side_r.center  <= side_w[STEPS].center;
      side_r.r2      <= side_w[STEPS].r2;
      lo_r <= hit ? mid_w[STEPS] : (mid_w[STEPS] & ~BIT);
    end
  end

  assign side_o = side_r;
  assign lo_o   = lo_r;

endmodule

@@ hw/rtl/pressure_by_polynomial_bisection_top.sv @@
// channel | ports                                  | payload
// input   | in_valid, in_stall (out), in_data      | in_beat_t  (point_x, point_y)
// result  | out_valid, out_stall (in), out_data    | out_beat_t (fraction, pressure, outside)
// config  | cfg_we, cfg_addr, cfg_wdata            | coeff_0..coeff_4, peak_level
// One beat enters per cycle while no result is stalled. The chain is a front
//   (squares, r^2, side register), then one bisect cell per result bit, each a
//   two-stage Horner multiply per coefficient below the top one plus a compare
//   stage, then an output register. Synchronous reset clears all valid bits, config to zero.
// A stalled result freezes the whole chain; in_stall follows out_valid && out_stall.
module pressure_by_polynomial_bisection_top
  import pbpb_pkg::*;
#(
  parameter int FRACTION_BITS = 24,
  parameter int COEFF_COUNT   = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data
);

  localparam int PX_W  = 2 * COORD_W;
  localparam int PRD_W = PEAK_W + OUT_FRAC_W;

  coef_arr_t           coeff_r;
  logic [PEAK_W-1:0]   peak_r;
  logic                adv;
  logic                v0_r, v1_r;
  logic signed [PX_W-1:0] px_r, py_r;
  logic [R2_W-1:0]     r2_r;
  side_t               side_s;
  side_t               side_w [FRACTION_BITS+1];
  logic [FRACTION_BITS-1:0] lo_w [FRACTION_BITS+1];
  logic [OUT_FRAC_W-1:0] frac_bis, frac_sel;
  logic                out_valid_r, outside_r;
  logic [OUT_FRAC_W-1:0] frac_r;
  logic [PRD_W-1:0]    prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      peak_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEFF0: coeff_r[0] <= cfg_wdata;
        REG_COEFF1: coeff_r[1] <= cfg_wdata;
        REG_COEFF2: coeff_r[2] <= cfg_wdata;
        REG_COEFF3: coeff_r[3] <= cfg_wdata;
        REG_COEFF4: coeff_r[4] <= cfg_wdata;
        REG_PEAK:   peak_r     <= cfg_wdata[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // front: squares, then r^2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= in_data.point_x * in_data.point_x;
      py_r <= in_data.point_y * in_data.point_y;
      r2_r <= R2_W'(px_r) + R2_W'(py_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_s.valid <= 1'b0;
    end else if (adv) begin
      side_s.valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_s.r2      <= r2_r;
      side_s.outside <= $signed({1'b0, r2_r}) >= $signed(coeff_r[0]);
      side_s.center  <= r2_r == '0;
    end
  end

  assign side_w[0] = side_s;
  assign lo_w[0]   = '0;

  for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_bit
    pbpb_bisect_cell #(
      .FRACTION_BITS(FRACTION_BITS),
      .COEFF_COUNT  (COEFF_COUNT),
      .BIT_POS      (FRACTION_BITS-1-k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .coeff_i(coeff_r),
      .side_i (side_w[k]),
      .lo_i   (lo_w[k]),
      .side_o (side_w[k+1]),
      .lo_o   (lo_w[k+1])
    );
  end

  if (FRACTION_BITS >= OUT_FRAC_W) begin : g_wide
    assign frac_bis = lo_w[FRACTION_BITS][FRACTION_BITS-1 -: OUT_FRAC_W];
  end else begin : g_narrow
    assign frac_bis = OUT_FRAC_W'(lo_w[FRACTION_BITS]) << (OUT_FRAC_W - FRACTION_BITS);
  end

  always_comb begin
    priority if (side_w[FRACTION_BITS].outside) begin
      frac_sel = '0;
    end else if (side_w[FRACTION_BITS].center) begin
      frac_sel = '1;
    end else begin
      frac_sel = frac_bis;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side_w[FRACTION_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frac_r    <= frac_sel;
      outside_r <= side_w[FRACTION_BITS].outside;
      prod_r    <= PRD_W'(peak_r) * PRD_W'(frac_sel);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data.fraction = frac_r;
  assign out_data.pressure = prod_r[PRD_W-1 -: PEAK_W];
  assign out_data.outside  = outside_r;

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outside |-> out_data.fraction == '0)
    else $error("outside result with nonzero fraction");

  a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fraction == '0 |-> out_data.pressure == '0)
    else $error("pressure without fraction");

  a_stall_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held result");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pbpb_pkg::*;

  localparam int FRAC_BITS = 24;
  localparam int N_COEF    = 5;
  localparam int LATENCY   = 4 + FRAC_BITS * (2 * (N_COEF - 1) + 1);
  localparam int N_RANDOM  = 900;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [2:0]       cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;

  pressure_by_polynomial_bisection_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow registers of the block
  logic signed [47:0] shadow_coef [N_COEF];
  logic [31:0]        shadow_peak;

  out_beat_t pending_q[$];
  int        n_err;
  int        n_out;
  int        n_inside;
  bit        rx_quiet;
  bit        tx_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("pressure_by_polynomial_bisection_top test failed");
    $finish;
  end

  // radius squared polynomial at midpoint m, Horner with truncation toward zero
  function automatic logic signed [63:0] radius_sq_at(logic [FRAC_BITS-1:0] m);
    logic signed [63:0]  acc;
    logic [63:0]         mag;
    logic [127:0]        prod;
    logic signed [63:0]  term;
    acc = 64'(shadow_coef[N_COEF-1]);
    for (int i = N_COEF - 2; i >= 0; i--) begin
      mag  = (acc < 0) ? -acc : acc;
      prod = 128'(mag) * 128'(m);
      term = 64'(prod >> FRAC_BITS);
      if (acc < 0) term = -term;
      acc = term + 64'(shadow_coef[i]);
    end
    return acc;
  endfunction

  function automatic out_beat_t predict_pressure(in_beat_t pt);
    out_beat_t          res;
    logic signed [63:0] x, y, r2, c0;
    logic [FRAC_BITS-1:0] lo, mid;
    logic [63:0]        prod;
    x  = 64'(pt.point_x);
    y  = 64'(pt.point_y);
    r2 = x * x + y * y;
    c0 = 64'(shadow_coef[0]);
    res = '0;
    if (r2 >= c0) begin
      res.outside = 1'b1;
    end else if (r2 == 0) begin
      res.fraction = '1;
    end else begin
      lo = '0;
      for (int k = FRAC_BITS - 1; k >= 0; k--) begin
        mid = lo | (FRAC_BITS'(1) << k);
        if (radius_sq_at(mid) > r2) lo = mid;
      end
      res.fraction = 24'(lo);
    end
    prod = 64'(shadow_peak) * 64'(res.fraction);
    res.pressure = 32'(prod >> 24);
    return res;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_PEAK) shadow_peak = val[31:0];
    else shadow_coef[idx] = val[47:0];
    @(posedge clk);
  endtask

  // load five polynomial coefficients and the peak level, e.g. a decreasing profile R(f) = c0 * (1 - f^p)
  task automatic load_profile(logic signed [47:0] c0, logic signed [47:0] c1,
                              logic signed [47:0] c2, logic signed [47:0] c3,
                              logic signed [47:0] c4, logic [31:0] peak);
    write_reg(REG_COEFF0, c0);
    write_reg(REG_COEFF1, c1);
    write_reg(REG_COEFF2, c2);
    write_reg(REG_COEFF3, c3);
    write_reg(REG_COEFF4, c4);
    write_reg(REG_PEAK, {16'h0, peak});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  // one beat; optional typed-in expectation
  task automatic send_point(in_beat_t pt, bit has_exp = 0, out_beat_t exp_res = '0);
    while (!tx_quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    pending_q.push_back(has_exp ? exp_res : predict_pressure(pt));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord(int span);
    int v;
    v = $urandom_range(2 * span) - span;
    return 24'(v);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          automatic out_beat_t want = pending_q.pop_front();
          n_out++;
          if (!want.outside) n_inside++;
          if (want.fraction != out_data.fraction || want.pressure != out_data.pressure
              || want.outside != out_data.outside) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch beat %0d: exp frac %h pres %h out %b, got frac %h pres %h out %b",
                       n_out, want.fraction, want.pressure, want.outside,
                       out_data.fraction, out_data.pressure, out_data.outside);
          end
        end
      end
      out_stall <= rx_quiet ? 1'b0 : ($urandom_range(99) < 13);
    end
  end

  typedef struct {
    logic [23:0] px;
    logic [23:0] py;
    bit          has_exp;
    out_beat_t   exp_res;
  } dir_row_t;

  localparam logic signed [47:0] ONE_Q40 = 48'sh100_0000_0000;

  initial begin
    dir_row_t  rows[$];
    in_beat_t  pt;
    int        phase;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    rx_quiet  = 1'b0;
    tx_quiet  = 1'b0;
    n_err     = 0;
    n_out     = 0;
    n_inside  = 0;
    for (int i = 0; i < N_COEF; i++) shadow_coef[i] = '0;
    shadow_peak = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset coeff_0 is 0, so every point is outside, center too
    send_point('{point_x: 24'sd0, point_y: 24'sd0}, 1, '{fraction: 24'd0, pressure: 0,
                                                        outside: 1'b1});
    send_point('{point_x: 24'h7FFFFF, point_y: 24'h800000}, 1,
               '{fraction: 24'd0, pressure: 0, outside: 1'b1});
    drain();

    // radius squared 4, linear profile R = 4 - 4f, full peak
    load_profile(4 * ONE_Q40, -4 * ONE_Q40, 0, 0, 0, 32'hFFFF_FFFF);
    rows = '{
      '{24'h000000, 24'h000000, 1, '{24'hFFFFFF, 32'hFFFF_FEFF, 1'b0}},
      '{24'h200000, 24'h000000, 1, '{24'h000000, 32'h0, 1'b1}},
      '{24'h000000, 24'hE00000, 1, '{24'h000000, 32'h0, 1'b1}},
      '{24'h7FFFFF, 24'h7FFFFF, 1, '{24'h000000, 32'h0, 1'b1}},
      '{24'h800000, 24'h800000, 1, '{24'h000000, 32'h0, 1'b1}},
      '{24'h800000, 24'h000000, 1, '{24'h000000, 32'h0, 1'b1}},
      '{24'h000001, 24'h000000, 0, '0},
      '{24'hFFFFFF, 24'hFFFFFF, 0, '0},
      '{24'h100000, 24'h000000, 0, '0},
      '{24'h1FFFFF, 24'h000000, 0, '0},
      '{24'h0AAAAA, 24'hF55555, 0, '0},
      '{24'h155555, 24'h0AAAAA, 0, '0}
    };
    foreach (rows[i]) begin
      pt.point_x = rows[i].px;
      pt.point_y = rows[i].py;
      send_point(pt, rows[i].has_exp, rows[i].exp_res);
    end
    drain();

    // non-monotone and extreme coefficients, negative radius
    load_profile(48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF,
                 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, 32'h8000_0001);
    send_point('{point_x: 24'h7FFFFF, point_y: 24'h7FFFFF});
    send_point('{point_x: 24'h123456, point_y: 24'h800000});
    send_point('{point_x: 24'h000003, point_y: 24'h000000});
    drain();
    write_reg(REG_COEFF0, 48'sh8000_0000_0000);
    send_point('{point_x: 24'd0, point_y: 24'd0}, 1, '{24'd0, 32'd0, 1'b1});
    drain();

    // random phases with fresh profiles
    for (phase = 0; phase < 6; phase++) begin
      logic signed [47:0] c0;
      int span;
      c0 = 48'($urandom_range(60, 1)) * ONE_Q40 + 48'($urandom);
      if (phase == 5) c0 = 48'sh7FFF_FFFF_FFFF;
      if (phase < 4)
        load_profile(c0, -c0 / ($urandom_range(4, 1)), -48'($urandom),
                     48'({$urandom, $urandom}) >>> 8, -c0 / 8, $urandom);
      else
        load_profile(c0, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     phase == 5 ? 32'hFFFF_FFFF : $urandom);
      tx_quiet = (phase == 2);
      rx_quiet = (phase == 2);
      span = (phase == 5) ? 8388607 : 4 * 1048576;
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        if ($urandom_range(15) == 0) begin
          pt.point_x = 24'($urandom);
          pt.point_y = 24'($urandom);
        end else begin
          pt.point_x = rand_coord(span);
          pt.point_y = rand_coord(span);
        end
        send_point(pt);
        // sender waits out the whole chain once per phase
        if (n == 40) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      drain();
    end

    $display("covered %0d result beats, %0d inside the patch, over reset, linear,",
             n_out, n_inside);
    $display("extreme, non-monotone and random polynomial settings with both sides stalling");
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("pressure_by_polynomial_bisection_top test passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("pressure_by_polynomial_bisection_top test failed");
    end
    $finish;
  end

endmodule

@@ pressure_by_polynomial_bisection_top.f @@
hw/rtl/pbpb_pkg.sv
hw/rtl/pbpb_horner_cell.sv
hw/rtl/pbpb_bisect_cell.sv
hw/rtl/pressure_by_polynomial_bisection_top.sv
dv/tb_top.sv
